// ----- sv/rxf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rxf_pkg
// Shared types and codes for the uart receive fifo with idle-gap framing.
// ----------------------------------------------------------------------------
package rxf_pkg;

  localparam int unsigned LEN_W    = 6;   // line_length width
  localparam int unsigned STAT_W   = 2;   // status width
  localparam int unsigned CNT_W    = 16;  // error counter width
  localparam int unsigned TIME_W   = 32;  // millisecond time width
  localparam int unsigned TMO_W    = 16;  // idle timeout width
  localparam int unsigned MLEN_W   = 7;   // max_len register width
  localparam int unsigned CFG_W    = 16;  // config write data width

  // config register indexes
  localparam logic CFG_MAX_LEN      = 1'b0;
  localparam logic CFG_IDLE_TIMEOUT = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_PENDING = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DELIVER = 2'd2;

  // command classes produced by the front end
  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_OVERRUN,
    CMD_FRAMING,
    CMD_POLL
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [7:0]        data;
    logic [TIME_W-1:0] now;
  } cmd_t;

  // queue status toward the back end
  typedef struct packed {
    logic empty;
    cmd_t head;
  } q_status_t;

endpackage
`default_nettype wire

// ----- sv/rxf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rxf_front
// Accepts command beats and classifies them into queue commands.
// ----------------------------------------------------------------------------
module rxf_front (
  input  wire logic                         start_i,
  input  wire logic                         operation_i,
  input  wire logic [7:0]                   rx_byte_i,
  input  wire logic                         overrun_flag_i,
  input  wire logic                         framing_flag_i,
  input  wire logic [rxf_pkg::TIME_W-1:0]   now_ms_i,
  input  wire logic                         q_full_i,
  output logic                              busy_o,
  output logic                              push_o,
  output rxf_pkg::cmd_t                     cmd_o
);
  import rxf_pkg::*;

  assign busy_o = q_full_i;
  assign push_o = start_i & ~q_full_i;

  // overrun wins over framing error
  always_comb begin
    cmd_o.data = rx_byte_i;
    cmd_o.now  = now_ms_i;
    if (operation_i) begin
      cmd_o.kind = CMD_POLL;
    end else if (overrun_flag_i) begin
      cmd_o.kind = CMD_OVERRUN;
    end else if (framing_flag_i) begin
      cmd_o.kind = CMD_FRAMING;
    end else begin
      cmd_o.kind = CMD_PUSH;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rxf_cmd_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rxf_cmd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rxf_cmd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rxf_pkg::cmd_t cmd_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output rxf_pkg::q_status_t status_o
);
  import rxf_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_pop;

  assign full_o          = (count_q == 2'd2);
  assign status_o.empty  = (count_q == 2'd0);
  assign status_o.head   = entry_q[rd_ptr_q];
  assign do_pop          = pop_i & ~status_o.empty;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

// ----- sv/rxf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rxf_back
// Executes queued commands: byte store, error counters, poll and delivery.
// ----------------------------------------------------------------------------
module rxf_back #(
  parameter int unsigned STORE_DEPTH = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire rxf_pkg::q_status_t          q_i,
  output logic                             pop_o,
  input  wire logic [rxf_pkg::LEN_W-1:0]   limit_i,
  input  wire logic [rxf_pkg::TMO_W-1:0]   idle_timeout_i,
  output logic                             strobe_o,
  output logic [rxf_pkg::STAT_W-1:0]       status_o,
  output logic [rxf_pkg::LEN_W-1:0]        line_length_o,
  output logic [7:0]                       data_out_o,
  output logic                             last_o,
  output logic [rxf_pkg::CNT_W-1:0]        overrun_total_o,
  output logic [rxf_pkg::CNT_W-1:0]        framing_total_o,
  output logic [rxf_pkg::CNT_W-1:0]        dropped_total_o
);
  import rxf_pkg::*;

  localparam int unsigned PTR_W = $clog2(STORE_DEPTH);
  localparam int unsigned CMP_W = (PTR_W > LEN_W) ? PTR_W : LEN_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STORE_DEPTH - 1);

  typedef enum logic {
    ST_IDLE,
    ST_DELIVER
  } state_e;

  state_e              state_q, state_d;
  logic [PTR_W-1:0]    wr_pos_q, wr_pos_d;
  logic [PTR_W-1:0]    rd_pos_q, rd_pos_d;
  logic [PTR_W-1:0]    seen_fill_q, seen_fill_d;
  logic [TIME_W-1:0]   gap_start_q, gap_start_d;
  logic [CNT_W-1:0]    ovr_cnt_q, ovr_cnt_d;
  logic [CNT_W-1:0]    frm_cnt_q, frm_cnt_d;
  logic [CNT_W-1:0]    drop_cnt_q, drop_cnt_d;
  logic [LEN_W-1:0]    remain_q, remain_d;
  logic                strobe_q, strobe_d;
  logic [STAT_W-1:0]   status_q, status_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic                last_q, last_d;

  logic [7:0]          store_q [STORE_DEPTH];
  logic [7:0]          rdata_q;
  logic                mem_we;
  logic                mem_re;

  logic [PTR_W-1:0]    fill;
  logic [CMP_W-1:0]    fill_x;
  logic [CMP_W-1:0]    lim_x;
  logic [CMP_W-1:0]    take_x;
  logic [TIME_W-1:0]   elapsed;

  // fill level of the circular store
  always_comb begin
    if (wr_pos_q >= rd_pos_q) begin
      fill = wr_pos_q - rd_pos_q;
    end else begin
      fill = PTR_W'({1'b0, wr_pos_q} + (PTR_W+1)'(STORE_DEPTH) - {1'b0, rd_pos_q});
    end
  end

  assign fill_x  = CMP_W'(fill);
  assign lim_x   = CMP_W'(limit_i);
  assign take_x  = (fill_x > lim_x) ? lim_x : fill_x;
  assign elapsed = q_i.head.now - gap_start_q;

  always_comb begin
    state_d     = state_q;
    wr_pos_d    = wr_pos_q;
    rd_pos_d    = rd_pos_q;
    seen_fill_d = seen_fill_q;
    gap_start_d = gap_start_q;
    ovr_cnt_d   = ovr_cnt_q;
    frm_cnt_d   = frm_cnt_q;
    drop_cnt_d  = drop_cnt_q;
    remain_d    = remain_q;
    strobe_d    = 1'b0;
    status_d    = status_q;
    len_d       = len_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    pop_o       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!q_i.empty) begin
          pop_o = 1'b1;
          case (q_i.head.kind)
            CMD_OVERRUN: ovr_cnt_d = ovr_cnt_q + 1'b1;
            CMD_FRAMING: frm_cnt_d = frm_cnt_q + 1'b1;
            CMD_PUSH: begin
              if (fill == PTR_LAST) begin
                drop_cnt_d = drop_cnt_q + 1'b1;
              end else begin
                mem_we   = 1'b1;
                wr_pos_d = (wr_pos_q == PTR_LAST) ? '0 : wr_pos_q + 1'b1;
              end
            end
            CMD_POLL: begin
              strobe_d = 1'b1;
              status_d = STAT_PENDING;
              len_d    = '0;
              last_d   = 1'b1;
              if (fill == '0) begin
                status_d = STAT_EMPTY;
              end else if (fill != seen_fill_q) begin
                if (fill_x > lim_x) begin
                  strobe_d    = 1'b0;
                  state_d     = ST_DELIVER;
                  remain_d    = limit_i;
                  len_d       = limit_i;
                  seen_fill_d = '0;
                end else begin
                  seen_fill_d = fill;
                  gap_start_d = q_i.head.now;
                end
              end else if (elapsed > TIME_W'(idle_timeout_i)) begin
                strobe_d    = 1'b0;
                state_d     = ST_DELIVER;
                remain_d    = take_x[LEN_W-1:0];
                len_d       = take_x[LEN_W-1:0];
                seen_fill_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DELIVER: begin
        // one byte read per cycle, shown on the next cycle
        mem_re   = 1'b1;
        rd_pos_d = (rd_pos_q == PTR_LAST) ? '0 : rd_pos_q + 1'b1;
        remain_d = remain_q - 1'b1;
        strobe_d = 1'b1;
        status_d = STAT_DELIVER;
        last_d   = (remain_q == LEN_W'(1));
        if (remain_q == LEN_W'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_pos_q    <= '0;
      rd_pos_q    <= '0;
      seen_fill_q <= '0;
      gap_start_q <= '0;
      ovr_cnt_q   <= '0;
      frm_cnt_q   <= '0;
      drop_cnt_q  <= '0;
      remain_q    <= '0;
      strobe_q    <= 1'b0;
      status_q    <= STAT_EMPTY;
      len_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_pos_q    <= wr_pos_d;
      rd_pos_q    <= rd_pos_d;
      seen_fill_q <= seen_fill_d;
      gap_start_q <= gap_start_d;
      ovr_cnt_q   <= ovr_cnt_d;
      frm_cnt_q   <= frm_cnt_d;
      drop_cnt_q  <= drop_cnt_d;
      remain_q    <= remain_d;
      strobe_q    <= strobe_d;
      status_q    <= status_d;
      len_q       <= len_d;
      last_q      <= last_d;
    end
  end

  // byte store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[wr_pos_q] <= q_i.head.data;
    end
    if (mem_re) begin
      rdata_q <= store_q[rd_pos_q];
    end
  end

  assign strobe_o        = strobe_q;
  assign status_o        = status_q;
  assign line_length_o   = (status_q == STAT_DELIVER) ? len_q : '0;
  assign data_out_o      = (status_q == STAT_DELIVER) ? rdata_q : 8'd0;
  assign last_o          = last_q;
  assign overrun_total_o = ovr_cnt_q;
  assign framing_total_o = frm_cnt_q;
  assign dropped_total_o = drop_cnt_q;

endmodule
`default_nettype wire

// ----- sv/uart_rx_fifo_idle_framer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uart_rx_fifo_idle_framer_top
// Uart receive fifo with overrun/framing filtering and idle-gap line framing.
// ----------------------------------------------------------------------------
// path: an empty/pending poll beat passes the queue and the result registers;
//   a delivery also passes the delivery state and the registered store read;
//   deliveries then stream 1 byte/cycle. The back end takes queued commands
//   one at a time, none while streaming (the single read port of the store)
// busy is high while the 2-entry command queue is full
// reset: pointers, counters and timer clear; the byte store is not cleared
// results cannot be stalled: each beat shows for one cycle on result_strobe_o
// ----------------------------------------------------------------------------
module uart_rx_fifo_idle_framer_top #(
  parameter int unsigned STORE_DEPTH = 256,
  parameter int unsigned MAX_LINE    = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // command side
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic                         operation_i,
  input  wire logic [7:0]                   rx_byte_i,
  input  wire logic                         overrun_flag_i,
  input  wire logic                         framing_flag_i,
  input  wire logic [rxf_pkg::TIME_W-1:0]   now_ms_i,
  // config write port
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_idx_i,
  input  wire logic [rxf_pkg::CFG_W-1:0]    cfg_wdata_i,
  // result side
  output logic                              result_strobe_o,
  output logic [rxf_pkg::STAT_W-1:0]        status_o,
  output logic [rxf_pkg::LEN_W-1:0]         line_length_o,
  output logic [7:0]                        data_out_o,
  output logic                              last_o,
  output logic [rxf_pkg::CNT_W-1:0]         overrun_total_o,
  output logic [rxf_pkg::CNT_W-1:0]         framing_total_o,
  output logic [rxf_pkg::CNT_W-1:0]         dropped_total_o
);
  import rxf_pkg::*;

  localparam logic [MLEN_W-1:0] MLEN_MIN = MLEN_W'(2);
  localparam logic [MLEN_W-1:0] MLEN_MAX = MLEN_W'(MAX_LINE);

  // config registers
  logic [MLEN_W-1:0] max_len_q;
  logic [TMO_W-1:0]  idle_timeout_q;
  logic [MLEN_W-1:0] max_len_clamped;
  logic [LEN_W-1:0]  limit;

  // front/queue/back links
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  cmd_t      front_cmd;
  q_status_t q_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q      <= MLEN_W'(64);
      idle_timeout_q <= TMO_W'(10);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_LEN:      max_len_q      <= cfg_wdata_i[MLEN_W-1:0];
        CFG_IDLE_TIMEOUT: idle_timeout_q <= cfg_wdata_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // buffer size clamped to [2, MAX_LINE]; line limit is one less
  always_comb begin
    if (max_len_q < MLEN_MIN) begin
      max_len_clamped = MLEN_MIN;
    end else if (max_len_q > MLEN_MAX) begin
      max_len_clamped = MLEN_MAX;
    end else begin
      max_len_clamped = max_len_q;
    end
  end
  assign limit = LEN_W'(max_len_clamped - 1'b1);

  // front end: accept and classify command beats
  rxf_front u_front (
    .start_i        (start_i),
    .operation_i    (operation_i),
    .rx_byte_i      (rx_byte_i),
    .overrun_flag_i (overrun_flag_i),
    .framing_flag_i (framing_flag_i),
    .now_ms_i       (now_ms_i),
    .q_full_i       (q_full),
    .busy_o         (busy_o),
    .push_o         (q_push),
    .cmd_o          (front_cmd)
  );

  // decouples acceptance from execution
  rxf_cmd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .cmd_i    (front_cmd),
    .pop_i    (q_pop),
    .full_o   (q_full),
    .status_o (q_status)
  );

  // back end: byte store, counters, poll decision and delivery
  rxf_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_i             (q_status),
    .pop_o           (q_pop),
    .limit_i         (limit),
    .idle_timeout_i  (idle_timeout_q),
    .strobe_o        (result_strobe_o),
    .status_o        (status_o),
    .line_length_o   (line_length_o),
    .data_out_o      (data_out_o),
    .last_o          (last_o),
    .overrun_total_o (overrun_total_o),
    .framing_total_o (framing_total_o),
    .dropped_total_o (dropped_total_o)
  );

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the uart receive fifo with idle-gap line framing.
// A queue of pending commands feeds a clocked driver; an in-bench fifo and
// timer model predicts every result beat, and a clocked monitor checks each
// strobed beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import rxf_pkg::*;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned MAX_LINE    = 64;
  localparam int unsigned PTR_W       = $clog2(STORE_DEPTH);
  localparam int unsigned SETTLE      = 16;      // quiet cycles after last beat
  localparam int unsigned CYCLE_LIMIT = 400000;  // watchdog

  // command codes on operation_i
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // one command beat as put on the ports
  typedef struct packed {
    logic              op;
    logic [7:0]        rx_byte;
    logic              ovr;
    logic              frm;
    logic [TIME_W-1:0] now;
  } rx_cmd_t;

  // one result beat as expected on the ports
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0]  line_len;
    logic [7:0]        data;
    logic              is_last;
    logic [CNT_W-1:0]  ovr_total;
    logic [CNT_W-1:0]  frm_total;
    logic [CNT_W-1:0]  drop_total;
  } rx_beat_t;

  // clock, reset and dut inputs, all known from time zero
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start_i        = 1'b0;
  logic                operation_i    = OP_BYTE;
  logic [7:0]          rx_byte_i      = '0;
  logic                overrun_flag_i = 1'b0;
  logic                framing_flag_i = 1'b0;
  logic [TIME_W-1:0]   now_ms_i       = '0;
  logic                cfg_we_i       = 1'b0;
  logic                cfg_idx_i      = CFG_MAX_LEN;
  logic [CFG_W-1:0]    cfg_wdata_i    = '0;

  logic                busy_o;
  logic                result_strobe_o;
  logic [STAT_W-1:0]   status_o;
  logic [LEN_W-1:0]    line_length_o;
  logic [7:0]          data_out_o;
  logic                last_o;
  logic [CNT_W-1:0]    overrun_total_o;
  logic [CNT_W-1:0]    framing_total_o;
  logic [CNT_W-1:0]    dropped_total_o;

  // queues between the stimulus, the driver and the monitor
  rx_cmd_t  cmd_backlog[$];
  rx_beat_t expected_beats[$];

  // model of the block: byte store, pointers, poll tracking, counters, config
  logic [7:0]        fifo_mem [STORE_DEPTH];
  int unsigned       wr_ptr      = 0;
  int unsigned       rd_ptr      = 0;
  int unsigned       polled_fill = 0;
  logic [TIME_W-1:0] idle_since  = '0;
  logic [CNT_W-1:0]  ovr_cnt     = '0;
  logic [CNT_W-1:0]  frm_cnt     = '0;
  logic [CNT_W-1:0]  drop_cnt    = '0;
  logic [MLEN_W-1:0] cfg_max_len = 7'd64;
  logic [TMO_W-1:0]  cfg_idle_tmo = 16'd10;

  // bookkeeping
  logic              sender_idle_en = 1'b1;
  logic [TIME_W-1:0] ms_clock;
  int unsigned       random_items   = 0;
  int unsigned       n_cmds         = 0;
  int unsigned       n_polls        = 0;
  int unsigned       n_lines        = 0;
  int unsigned       n_beats        = 0;
  int unsigned       n_reg_writes   = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count    = 0;

  uart_rx_fifo_idle_framer_top #(
    .STORE_DEPTH(STORE_DEPTH),
    .MAX_LINE   (MAX_LINE)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .rx_byte_i      (rx_byte_i),
    .overrun_flag_i (overrun_flag_i),
    .framing_flag_i (framing_flag_i),
    .now_ms_i       (now_ms_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_strobe_o(result_strobe_o),
    .status_o       (status_o),
    .line_length_o  (line_length_o),
    .data_out_o     (data_out_o),
    .last_o         (last_o),
    .overrun_total_o(overrun_total_o),
    .framing_total_o(framing_total_o),
    .dropped_total_o(dropped_total_o)
  );

  // 2 ns clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // queue one expected beat, counters as they stand right now
  task automatic push_beat(input logic [STAT_W-1:0] st, input logic [LEN_W-1:0] len,
                           input logic [7:0] data, input logic lst);
    rx_beat_t b;
    b = '{st, len, data, lst, ovr_cnt, frm_cnt, drop_cnt};
    expected_beats.push_back(b);
  endtask

  // advance the model by one accepted command and queue its beats
  task automatic apply_cmd(input rx_cmd_t c);
    int unsigned       fill;
    int unsigned       lim;
    int unsigned       take;
    logic [TIME_W-1:0] elapsed;
    fill = (wr_ptr + STORE_DEPTH - rd_ptr) % STORE_DEPTH;
    if (c.op == OP_BYTE) begin
      // overrun wins over framing; a full store drops the byte
      if (c.ovr) ovr_cnt++;
      else if (c.frm) frm_cnt++;
      else if (fill >= STORE_DEPTH - 1) drop_cnt++;
      else begin
        fifo_mem[PTR_W'(wr_ptr)] = c.rx_byte;
        wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
      end
    end else begin
      n_polls++;
      // max_len below 2 acts as 2, above the line cap acts as the cap
      if (cfg_max_len < 2) lim = 1;
      else if (cfg_max_len > MAX_LINE) lim = MAX_LINE - 1;
      else lim = cfg_max_len - 1;
      elapsed = c.now - idle_since;   // wraps mod 2^32
      take = 0;
      if (fill == 0) begin
        push_beat(STAT_EMPTY, '0, '0, 1'b1);
      end else if (fill != polled_fill) begin
        if (fill > lim) take = lim;
        else begin
          // new bytes: restart the idle gap
          polled_fill = fill;
          idle_since  = c.now;
          push_beat(STAT_PENDING, '0, '0, 1'b1);
        end
      end else if (elapsed > TIME_W'(cfg_idle_tmo)) begin
        take = (fill > lim) ? lim : fill;
      end else begin
        push_beat(STAT_PENDING, '0, '0, 1'b1);
      end
      if (take != 0) begin
        for (int i = 0; i < take; i++) begin
          push_beat(STAT_DELIVER, take[LEN_W-1:0], fifo_mem[PTR_W'(rd_ptr)],
                    i == take - 1);
          rd_ptr = (rd_ptr + 1) % STORE_DEPTH;
        end
        polled_fill = 0;
        n_lines++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // driver: one command beat at a time from the backlog, random hold-offs
  // --------------------------------------------------------------------------
  rx_cmd_t     cmd_on_port = '0;
  int unsigned hold_off    = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      // beat taken at this edge: run it through the model
      if (start_i && !busy_o) begin
        apply_cmd(cmd_on_port);
        n_cmds++;
      end
      // port is free unless a beat is held against busy
      if (!start_i || !busy_o) begin
        if (hold_off != 0) begin
          start_i  <= 1'b0;
          hold_off <= hold_off - 1;
        end else if (cmd_backlog.size() != 0) begin
          cmd_on_port     = cmd_backlog.pop_front();
          start_i        <= 1'b1;
          operation_i    <= cmd_on_port.op;
          rx_byte_i      <= cmd_on_port.rx_byte;
          overrun_flag_i <= cmd_on_port.ovr;
          framing_flag_i <= cmd_on_port.frm;
          now_ms_i       <= cmd_on_port.now;
          // gap burst after this beat now and then
          if (sender_idle_en && $urandom_range(0, 3) == 0)
            hold_off <= $urandom_range(1, 7);
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitor: every strobed beat against the oldest prediction
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t, beat %0d: %s", $realtime, n_beats, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got)
      report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
  endtask

  always @(posedge clk_i) begin
    rx_beat_t want;
    if (rst_ni && result_strobe_o) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_beats.pop_front();
        check_field("status",        32'(want.status),     32'(status_o));
        check_field("line_length",   32'(want.line_len),   32'(line_length_o));
        check_field("data_out",      32'(want.data),       32'(data_out_o));
        check_field("last",          32'(want.is_last),    32'(last_o));
        check_field("overrun_total", 32'(want.ovr_total),  32'(overrun_total_o));
        check_field("framing_total", 32'(want.frm_total),  32'(framing_total_o));
        check_field("dropped_total", 32'(want.drop_total), 32'(dropped_total_o));
      end
      n_beats++;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected",
               cycle_count, expected_beats.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] data, input logic ovr, input logic frm);
    rx_cmd_t c;
    c = '{OP_BYTE, data, ovr, frm, TIME_W'($urandom)};   // time is ignored here
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_poll(input logic [TIME_W-1:0] now);
    rx_cmd_t c;
    c = '{OP_POLL, 8'($urandom), 1'($urandom), 1'($urandom), now};
    cmd_backlog.push_back(c);
  endtask

  // wait until the block has drained and gone quiet, sampled between edges
  task automatic wait_quiet();
    @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start_i || busy_o || expected_beats.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // config write, only called while the block is idle
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    if (idx == CFG_MAX_LEN) cfg_max_len = val[MLEN_W-1:0];
    else cfg_idle_tmo = val[TMO_W-1:0];
    n_reg_writes++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one line of traffic: bytes with some errors, then polls over time
  task automatic random_burst();
    int unsigned nbytes;
    int unsigned npolls;
    int unsigned r;
    nbytes = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 12);
    for (int i = 0; i < nbytes; i++) begin
      r = $urandom_range(0, 15);
      queue_byte(8'($urandom), r == 0 || r == 2, r == 1 || r == 2);
      random_items++;
      // stray poll in the middle of a line
      if ($urandom_range(0, 19) == 0) begin
        queue_poll(ms_clock);
        random_items++;
      end
    end
    npolls = $urandom_range(1, 4);
    for (int i = 0; i < npolls; i++) begin
      // step the time around the timeout edge, or jump far (wraps)
      case ($urandom_range(0, 5))
        0: ms_clock = ms_clock;
        1: ms_clock = ms_clock + TIME_W'(cfg_idle_tmo);
        2: ms_clock = ms_clock + TIME_W'(cfg_idle_tmo) + 1;
        3: ms_clock = ms_clock + $urandom_range(0, 40);
        4: ms_clock = ms_clock + $urandom;
        default: ms_clock = ms_clock + TIME_W'(cfg_idle_tmo) + $urandom_range(2, 100);
      endcase
      queue_poll(ms_clock);
      random_items++;
    end
  endtask

  // new settings, then random lines until the item budget is used
  task automatic random_phase(input logic [CFG_W-1:0] max_len,
                              input logic [CFG_W-1:0] tmo, input int unsigned n_items);
    int unsigned base;
    wait_quiet();
    write_reg(CFG_MAX_LEN, max_len);
    write_reg(CFG_IDLE_TIMEOUT, tmo);
    base = random_items;
    while (random_items - base < n_items) random_burst();
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    ms_clock = $urandom;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: max_len 64, timeout 10
    queue_poll(32'd5);                    // poll on an empty store
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hA5, 1'b1, 1'b0);        // overrun, discarded
    queue_byte(8'h3C, 1'b0, 1'b1);        // framing error, discarded
    queue_byte(8'h81, 1'b1, 1'b1);        // both flags, overrun counted only
    queue_poll(32'h0000_1000);            // fill changed: pending, timer restarts
    queue_poll(32'h0000_100A);            // gap equals timeout: still pending
    queue_poll(32'h0000_100B);            // gap past timeout: line of two
    queue_poll(32'h0000_100B);            // empty again, state kept
    queue_byte(8'h5A, 1'b0, 1'b0);
    queue_poll(32'hFFFF_FFF8);            // pending near the top of time
    queue_poll(32'h0000_0004);            // gap across the wrap is 12
    wait_quiet();

    // smallest line, zero timeout
    write_reg(CFG_MAX_LEN, 16'd1);
    write_reg(CFG_IDLE_TIMEOUT, 16'd0);
    queue_byte(8'h11, 1'b0, 1'b0);
    queue_byte(8'h22, 1'b0, 1'b0);
    queue_byte(8'h33, 1'b0, 1'b0);
    queue_poll(32'd100);                  // more than the limit: one byte out
    queue_poll(32'd100);                  // fill changed again, still above
    queue_poll(32'd100);                  // at the limit: pending
    queue_poll(32'd100);                  // zero gap is not past zero timeout
    queue_poll(32'd101);                  // one byte line
    wait_quiet();

    // max_len of zero behaves as two
    write_reg(CFG_MAX_LEN, 16'd0);
    queue_byte(8'h77, 1'b0, 1'b0);
    queue_byte(8'h88, 1'b0, 1'b0);
    queue_poll(32'd7);
    queue_poll(32'd7);

    // random lines under several settings, idle gaps on the command side
    random_phase(16'($urandom_range(2, 64)), 16'($urandom_range(0, 20)), 15);
    random_phase(16'd127, 16'd65535, 12);          // above the line cap, longest gap
    random_phase(16'd2, 16'd0, 10);

    // last stretch back to back
    wait_quiet();
    sender_idle_en = 1'b0;
    random_phase(16'd64, 16'($urandom_range(0, 65535)), 15);

    wait_quiet();
    $display("ran %0d commands (%0d polls) over %0d register writes", n_cmds, n_polls,
             n_reg_writes);
    $display("checked %0d result beats, %0d lines delivered, %0d bytes dropped",
             n_beats, n_lines, drop_cnt);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
